### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Wrappers for concurrent assertions. They reduce to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// When ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// When ante holds at a clock edge, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/dllm_pkg.sv
// ----------------------------------------------------------------------------
// Linked list manager package
// Node id sizes, action codes and the request and result beat formats.
// ----------------------------------------------------------------------------
`default_nettype none

package dllm_pkg;

	localparam int NODES = 64;
	localparam int NW    = $clog2(NODES);
	localparam int IDW   = $clog2(NODES + 1);

	// Node id value that stands for "no node".
	localparam logic [IDW-1:0] NONE_ID = IDW'(NODES);

	typedef enum logic [2:0] {
		ACT_ADD_HEAD = 3'd0,
		ACT_ADD_TAIL = 3'd1,
		ACT_REMOVE   = 3'd2,
		ACT_POP_HEAD = 3'd3,
		ACT_POP_TAIL = 3'd4,
		ACT_MOVE     = 3'd5,
		ACT_QUERY    = 3'd6
	} action_t;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] node;
	} req_t;

	typedef struct packed {
		logic [6:0] node_out;
		logic       ok;
		logic       empty_res;
		logic [6:0] length;
		logic [6:0] head_node;
	} res_t;

endpackage

`default_nettype wire

### hdl/dllm_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload; a beat moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface dllm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/dllm_core.sv
// ----------------------------------------------------------------------------
// List state and update logic
// Holds links, head, tail, count and listed flags; computes one action.
// ----------------------------------------------------------------------------
`default_nettype none

module dllm_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  ld,
	input  wire logic [dllm_pkg::NW-1:0] ld_node,
	input  wire dllm_pkg::req_t        req_in,
	output dllm_pkg::res_t             res_next
);
	import dllm_pkg::*;

	typedef struct packed {
		logic            we;
		logic [NW-1:0]   addr;
		logic [IDW-1:0]  data;
	} lwr_t;

	logic [IDW-1:0] next_q [NODES];
	logic [IDW-1:0] prev_q [NODES];
	logic [NODES-1:0] listed_q;
	logic [IDW-1:0] head_q;
	logic [IDW-1:0] tail_q;
	logic [IDW-1:0] count_q;

	logic [NW-1:0]  n;
	logic [IDW-1:0] n_id;
	logic [NW-1:0]  hi;
	logic [NW-1:0]  ti;
	logic           head_v;
	logic           tail_v;
	logic           is_listed;
	logic           n_is_head;
	logic           n_is_tail;
	logic [IDW-1:0] n_prev;
	logic [IDW-1:0] n_next;
	logic [IDW-1:0] head_nxt_lnk;
	logic [IDW-1:0] tail_prv_lnk;

	lwr_t           nx_w0, nx_w1, pv_w0, pv_w1;
	logic [IDW-1:0] head_d, tail_d, count_d;
	logic           lst_set, lst_clr;
	logic [NW-1:0]  lst_idx;
	logic [IDW-1:0] popped;
	logic           ok;
	logic           u_do;
	logic [NW-1:0]  u_idx;
	logic [IDW-1:0] u_p, u_q;

	logic [NW-1:0]  h_ld;
	logic [NW-1:0]  t_ld;
	logic [IDW-1:0] nxt_n_d, prv_n_d, nxt_h_d, prv_t_d;
	logic           lst_n_d;
	logic [IDW-1:0] nxt_n_s1, prv_n_s1, nxt_h_s1, prv_t_s1;
	logic           lst_n_s1;

	// Links of the head's prev and the tail's next are not relied on; they are
	// taken as "none" from the head and tail pointers, so no write need clear them.
	always_comb begin
		n            = req_in.node;
		n_id         = {1'b0, n};
		hi           = head_q[NW-1:0];
		ti           = tail_q[NW-1:0];
		head_v       = (head_q != NONE_ID);
		tail_v       = (tail_q != NONE_ID);
		is_listed    = lst_n_s1;
		n_is_head    = (head_q == n_id);
		n_is_tail    = (tail_q == n_id);
		n_prev       = n_is_head ? NONE_ID : prv_n_s1;
		n_next       = n_is_tail ? NONE_ID : nxt_n_s1;
		head_nxt_lnk = (head_q == tail_q) ? NONE_ID : nxt_h_s1;
		tail_prv_lnk = (head_q == tail_q) ? NONE_ID : prv_t_s1;
	end

	always_comb begin
		nx_w0   = '0;
		nx_w1   = '0;
		pv_w0   = '0;
		pv_w1   = '0;
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		lst_set = 1'b0;
		lst_clr = 1'b0;
		lst_idx = n;
		popped  = NONE_ID;
		ok      = 1'b0;
		u_do    = 1'b0;
		u_idx   = n;
		u_p     = NONE_ID;
		u_q     = NONE_ID;

		case (action_t'(req_in.action))
			ACT_ADD_HEAD: begin
				if (!is_listed) begin
					ok      = 1'b1;
					pv_w0   = '{we: head_v, addr: hi, data: n_id};
					nx_w0   = '{we: 1'b1, addr: n, data: head_q};
					head_d  = n_id;
					if (!tail_v)
						tail_d = n_id;
					lst_set = 1'b1;
					count_d = count_q + IDW'(1);
				end
			end
			ACT_ADD_TAIL: begin
				if (!is_listed) begin
					ok      = 1'b1;
					nx_w0   = '{we: tail_v, addr: ti, data: n_id};
					pv_w0   = '{we: 1'b1, addr: n, data: tail_q};
					tail_d  = n_id;
					if (!head_v)
						head_d = n_id;
					lst_set = 1'b1;
					count_d = count_q + IDW'(1);
				end
			end
			ACT_REMOVE: begin
				if (is_listed) begin
					ok    = 1'b1;
					u_do  = 1'b1;
					u_idx = n;
					u_p   = n_prev;
					u_q   = n_next;
				end
			end
			ACT_POP_HEAD: begin
				if (head_v) begin
					ok     = 1'b1;
					popped = head_q;
					u_do   = 1'b1;
					u_idx  = hi;
					u_p    = NONE_ID;
					u_q    = head_nxt_lnk;
				end
			end
			ACT_POP_TAIL: begin
				if (tail_v) begin
					ok     = 1'b1;
					popped = tail_q;
					u_do   = 1'b1;
					u_idx  = ti;
					u_p    = tail_prv_lnk;
					u_q    = NONE_ID;
				end
			end
			ACT_MOVE: begin
				if (is_listed) begin
					ok = 1'b1;
					// A listed node that is not the head always has a predecessor.
					if (!n_is_head) begin
						nx_w0 = '{we: 1'b1, addr: n_prev[NW-1:0], data: n_next};
						if (n_next != NONE_ID)
							pv_w0 = '{we: 1'b1, addr: n_next[NW-1:0], data: n_prev};
						else
							tail_d = n_prev;
						pv_w1  = '{we: 1'b1, addr: hi, data: n_id};
						nx_w1  = '{we: 1'b1, addr: n, data: head_q};
						head_d = n_id;
					end
				end
			end
			ACT_QUERY: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		if (u_do) begin
			if (u_p != NONE_ID)
				nx_w0 = '{we: 1'b1, addr: u_p[NW-1:0], data: u_q};
			else
				head_d = u_q;
			if (u_q != NONE_ID)
				pv_w0 = '{we: 1'b1, addr: u_q[NW-1:0], data: u_p};
			else
				tail_d = u_p;
			count_d = count_q - IDW'(1);
			lst_clr = 1'b1;
			lst_idx = u_idx;
		end
	end

	// The links an action needs are read when its request beat is taken. The
	// head and tail it will see are those left by the action that completes in
	// the same cycle, and that action's writes are passed straight through.
	always_comb begin
		h_ld    = en ? head_d[NW-1:0] : hi;
		t_ld    = en ? tail_d[NW-1:0] : ti;
		nxt_n_d = next_q[ld_node];
		nxt_h_d = next_q[h_ld];
		prv_n_d = prev_q[ld_node];
		prv_t_d = prev_q[t_ld];
		lst_n_d = listed_q[ld_node];
		if (en) begin
			if (nx_w0.we && nx_w0.addr == ld_node)
				nxt_n_d = nx_w0.data;
			if (nx_w1.we && nx_w1.addr == ld_node)
				nxt_n_d = nx_w1.data;
			if (nx_w0.we && nx_w0.addr == h_ld)
				nxt_h_d = nx_w0.data;
			if (nx_w1.we && nx_w1.addr == h_ld)
				nxt_h_d = nx_w1.data;
			if (pv_w0.we && pv_w0.addr == ld_node)
				prv_n_d = pv_w0.data;
			if (pv_w1.we && pv_w1.addr == ld_node)
				prv_n_d = pv_w1.data;
			if (pv_w0.we && pv_w0.addr == t_ld)
				prv_t_d = pv_w0.data;
			if (pv_w1.we && pv_w1.addr == t_ld)
				prv_t_d = pv_w1.data;
			if ((lst_set || lst_clr) && lst_idx == ld_node)
				lst_n_d = lst_set;
		end
	end

	always_comb begin
		res_next.node_out  = popped;
		res_next.ok        = ok;
		res_next.empty_res = (count_d == '0);
		res_next.length    = count_d;
		res_next.head_node = head_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (nx_w0.we)
				next_q[nx_w0.addr] <= nx_w0.data;
			if (nx_w1.we)
				next_q[nx_w1.addr] <= nx_w1.data;
			if (pv_w0.we)
				prev_q[pv_w0.addr] <= pv_w0.data;
			if (pv_w1.we)
				prev_q[pv_w1.addr] <= pv_w1.data;
		end
		if (ld) begin
			nxt_n_s1 <= nxt_n_d;
			nxt_h_s1 <= nxt_h_d;
			prv_n_s1 <= prv_n_d;
			prv_t_s1 <= prv_t_d;
			lst_n_s1 <= lst_n_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= NONE_ID;
			tail_q   <= NONE_ID;
			count_q  <= '0;
			listed_q <= '0;
		end else if (en) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (lst_set)
				listed_q[lst_idx] <= 1'b1;
			if (lst_clr)
				listed_q[lst_idx] <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hdl/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// Doubly linked list manager
// One list over a pool of 64 node ids, one action per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (action, node) and each one yields exactly one
//   result beat on res (node_out, ok, empty_res, length, head_node).
//   A request beat is registered at acceptance, together with the links it
//   will need; once the output register is free the action is applied to
//   the list and its result registered in the output register.
//   Throughput is one request per cycle while res is not stalled: the list
//   update is a single pass of logic on the link registers, and the input
//   register refills in the same cycle that it hands its request on.
//   When res is stalled, one request waits in the input register and one
//   result in the output register; req.ready then drops until res moves.
//   Reset empties the list at once (head, tail and count cleared, all listed
//   flags cleared); no clearing pass follows and req.ready is high after it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module doubly_linked_list_manager (
	input  wire logic      clk,
	input  wire logic      arst_n,
	dllm_stream_if.sink    req,
	dllm_stream_if.source  res
);
	import dllm_pkg::*;

	req_t req_s1;
	logic req_vld_s1;
	res_t res_s2;
	logic res_vld_s2;
	res_t res_next;
	logic out_free;
	logic advance;
	logic in_beat;

	assign out_free  = !res_vld_s2 || res.ready;
	assign advance   = req_vld_s1 && out_free;
	assign req.ready = !req_vld_s1 || advance;
	assign in_beat   = req.valid && req.ready;

	dllm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.ld       (in_beat),
		.ld_node  (req.data.node),
		.req_in   (req_s1),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
			res_vld_s2 <= 1'b0;
		end else begin
			if (in_beat)
				req_vld_s1 <= 1'b1;
			else if (advance)
				req_vld_s1 <= 1'b0;
			if (advance)
				res_vld_s2 <= 1'b1;
			else if (res.ready)
				res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat)
			req_s1 <= req.data;
		if (advance)
			res_s2 <= res_next;
	end

	assign res.valid = res_vld_s2;
	assign res.data  = res_s2;

	`ASSERT_IMPL(a_ready_when_free, clk, arst_n, !req_vld_s1, req.ready)
	`ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, res_vld_s2)
	`ASSERT_NEXT(a_accept_loads_s1, clk, arst_n, in_beat, req_vld_s1)
	`ASSERT_IMPL(a_empty_has_no_head, clk, arst_n, res_vld_s2 && res_s2.empty_res, res_s2.head_node == NONE_ID)

endmodule

`default_nettype wire
